// ----- rtl/relay_feedback_autotuner_macros.svh -----
// ----------------------------------------------------------------------------
// Relay-feedback autotuner assertion macros
// Shared assertion forms for the autotuner RTL.
// ----------------------------------------------------------------------------
`ifndef RELAY_FEEDBACK_AUTOTUNER_MACROS_SVH
`define RELAY_FEEDBACK_AUTOTUNER_MACROS_SVH

// same-cycle implication
`define RFA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/rfa_pkg.sv -----
// ----------------------------------------------------------------------------
// Relay-feedback autotuner package
// Field widths, codes and transaction types shared by the autotuner modules.
// ----------------------------------------------------------------------------
package rfa_pkg;

	localparam int SAMPLE_W  = 24;
	localparam int TIME_W    = 32;
	localparam int AMP_W     = 23;
	localparam int CYC_W     = 8;
	localparam int SUM_W     = 40;
	localparam int ASUM_W    = 32;
	localparam int DIV_NUM_W = 41;
	localparam int DIV_DEN_W = 24;
	localparam int CONST_W   = 34;
	localparam int SPLIT_W   = 17;
	localparam int ACC_W     = AMP_W + CONST_W;
	localparam int CFG_AW    = 5;
	localparam int CFG_DW    = 32;

	localparam logic [CONST_W-1:0] INV_PI_Q35 = 34'd10937044409;

	localparam logic [1:0] KIND_SAMPLE = 2'd0;
	localparam logic [1:0] KIND_START  = 2'd1;
	localparam logic [1:0] KIND_ABORT  = 2'd2;

	localparam logic [2:0] REG_OUTPUT_MIN      = 3'd0;
	localparam logic [2:0] REG_OUTPUT_MAX      = 3'd1;
	localparam logic [2:0] REG_PV_MIN          = 3'd2;
	localparam logic [2:0] REG_PV_MAX          = 3'd3;
	localparam logic [2:0] REG_RELAY_AMPLITUDE = 3'd4;
	localparam logic [2:0] REG_HYSTERESIS_BAND = 3'd5;
	localparam logic [2:0] REG_CYCLES_REQUIRED = 3'd6;
	localparam logic [2:0] REG_MAX_TEST_MS     = 3'd7;

	typedef enum logic [1:0] {
		OP_SAMPLE,
		OP_START,
		OP_ABORT,
		OP_NONE
	} op_t;

	typedef enum logic [1:0] {
		RUN_IDLE   = 2'd0,
		RUN_ACTIVE = 2'd1,
		RUN_DONE   = 2'd2,
		RUN_ABORT  = 2'd3
	} run_t;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_CONFIG    = 3'd1,
		ERR_PV_LOW    = 3'd2,
		ERR_PV_HIGH   = 3'd3,
		ERR_OP_LIMIT  = 3'd4,
		ERR_NO_OSC    = 3'd5,
		ERR_TIMEOUT   = 3'd6,
		ERR_USER      = 3'd7
	} err_t;

	typedef struct packed {
		logic [1:0]                 kind;
		logic signed [SAMPLE_W-1:0] pv_sample;
		logic signed [SAMPLE_W-1:0] op_readback;
		logic [TIME_W-1:0]          now_ms;
		logic signed [SAMPLE_W-1:0] reference_pv;
		logic                       use_current_reference;
		logic                       reverse_action;
	} item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] drive_value;
		logic                       relay_is_high;
		logic [1:0]                 run_state;
		logic [2:0]                 error_code;
		logic [CYC_W-1:0]           completed_cycles;
		logic [31:0]                ku_average;
		logic [TIME_W-1:0]          tu_average_ms;
		logic [SAMPLE_W-1:0]        amplitude_average;
		logic                       result_valid;
	} res_t;

	typedef struct packed {
		op_t                        op;
		logic signed [SAMPLE_W-1:0] pv;
		logic signed [SAMPLE_W-1:0] opr;
		logic [TIME_W-1:0]          now;
		logic signed [SAMPLE_W-1:0] ref_pv;
		logic                       use_cur;
		logic                       rev;
	} cmd_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] output_min;
		logic signed [SAMPLE_W-1:0] output_max;
		logic signed [SAMPLE_W-1:0] pv_min;
		logic signed [SAMPLE_W-1:0] pv_max;
		logic [AMP_W-1:0]           relay_amplitude;
		logic [AMP_W-1:0]           hysteresis_band;
		logic [CYC_W-1:0]           cycles_required;
		logic [TIME_W-1:0]          max_test_ms;
	} cfg_t;

endpackage

// ----- rtl/rfa_front.sv -----
// ----------------------------------------------------------------------------
// Autotuner front end
// Accepts input transactions, classifies their kind and pushes them to the queue.
// ----------------------------------------------------------------------------
module rfa_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  rfa_pkg::item_t in_item,
	input  logic          q_full,
	output logic          push,
	output rfa_pkg::cmd_t push_cmd
);

	logic          valid_s1;
	rfa_pkg::cmd_t cmd_s1;
	rfa_pkg::cmd_t cmd_new;

	assign push     = valid_s1 && !q_full;
	assign in_stall = valid_s1 && q_full;
	assign push_cmd = cmd_s1;

	always_comb begin
		cmd_new.pv      = in_item.pv_sample;
		cmd_new.opr     = in_item.op_readback;
		cmd_new.now     = in_item.now_ms;
		cmd_new.ref_pv  = in_item.reference_pv;
		cmd_new.use_cur = in_item.use_current_reference;
		cmd_new.rev     = in_item.reverse_action;
		unique case (in_item.kind)
			rfa_pkg::KIND_SAMPLE: cmd_new.op = rfa_pkg::OP_SAMPLE;
			rfa_pkg::KIND_START:  cmd_new.op = rfa_pkg::OP_START;
			rfa_pkg::KIND_ABORT:  cmd_new.op = rfa_pkg::OP_ABORT;
			default:              cmd_new.op = rfa_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			cmd_s1 <= cmd_new;
		end
	end

endmodule

// ----- rtl/rfa_fifo.sv -----
// ----------------------------------------------------------------------------
// Autotuner command queue
// Short register queue between the front end and the execution engine.
// ----------------------------------------------------------------------------
module rfa_fifo #(
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rfa_pkg::cmd_t push_data,
	output logic          full,
	input  logic          pop,
	output rfa_pkg::cmd_t pop_data,
	output logic          empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	rfa_pkg::cmd_t    mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full     = cnt_q == CNT_W'(DEPTH);
	assign empty    = cnt_q == '0;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

// ----- rtl/rfa_div.sv -----
// ----------------------------------------------------------------------------
// Autotuner divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rfa_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rfa_pkg::DIV_NUM_W-1:0] num,
	input  logic [rfa_pkg::DIV_DEN_W-1:0] den,
	output logic                          busy,
	output logic                          done,
	output logic [rfa_pkg::DIV_NUM_W-1:0] quo
);

	localparam int NW = rfa_pkg::DIV_NUM_W;
	localparam int DW = rfa_pkg::DIV_DEN_W;
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] work_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic          ge;
	logic [DW:0]   diff;

	assign trial = {rem_q, work_q[NW-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};
	assign busy  = busy_q;
	assign done  = done_q;
	assign quo   = work_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && cnt_q == CW'(1);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= num;
			rem_q  <= '0;
			den_q  <= den;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[DW-1:0] : trial[DW-1:0];
			work_q <= {work_q[NW-2:0], ge};
		end
	end

endmodule

// ----- rtl/rfa_back.sv -----
// ----------------------------------------------------------------------------
// Autotuner execution engine
// Runs start, sample and abort commands, measures cycles and holds the result.
// ----------------------------------------------------------------------------
`include "relay_feedback_autotuner_macros.svh"

module rfa_back (
	input  logic          clk,
	input  logic          arst_n,
	input  rfa_pkg::cfg_t cfg,
	input  logic          q_empty,
	input  rfa_pkg::cmd_t q_data,
	output logic          q_pop,
	output logic          out_valid,
	input  logic          out_stall,
	output rfa_pkg::res_t out_item
);

	localparam int SW = rfa_pkg::SAMPLE_W;
	localparam int TW = rfa_pkg::TIME_W;
	localparam int MW = rfa_pkg::AMP_W + rfa_pkg::SPLIT_W;
	localparam logic [rfa_pkg::SPLIT_W-1:0] C_LO = rfa_pkg::INV_PI_Q35[rfa_pkg::SPLIT_W-1:0];
	localparam logic [rfa_pkg::SPLIT_W-1:0] C_HI =
		rfa_pkg::INV_PI_Q35[rfa_pkg::CONST_W-1:rfa_pkg::SPLIT_W];

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_EXEC   = 10'b0000000010,
		S_MUL_LO = 10'b0000000100,
		S_MUL_HI = 10'b0000001000,
		S_DIV_KU = 10'b0000010000,
		S_DIV_KM = 10'b0000100000,
		S_DIV_TM = 10'b0001000000,
		S_DIV_AM = 10'b0010000000,
		S_POST   = 10'b0100000000,
		S_EMIT   = 10'b1000000000
	} st_t;

	st_t                             state_q;
	rfa_pkg::cmd_t                   cmd_q;
	rfa_pkg::run_t                   test_q;
	rfa_pkg::err_t                   err_q;
	logic                            relay_q;
	logic                            pos_q;
	logic signed [SW-1:0]            bias_q;
	logic signed [SW-1:0]            hi_q;
	logic signed [SW-1:0]            lo_q;
	logic signed [SW-1:0]            ref_q;
	logic [TW-1:0]                   start_t_q;
	logic [TW-1:0]                   lht_q;
	logic                            started_q;
	logic                            warm_q;
	logic signed [SW-1:0]            clo_q;
	logic signed [SW-1:0]            chi_q;
	logic [rfa_pkg::SUM_W-1:0]       kusum_q;
	logic [rfa_pkg::SUM_W-1:0]       tusum_q;
	logic [rfa_pkg::ASUM_W-1:0]      ampsum_q;
	logic [rfa_pkg::CYC_W-1:0]       cnt_q;
	logic [31:0]                     kumean_q;
	logic [TW-1:0]                   tumean_q;
	logic [SW-1:0]                   ampmean_q;
	logic [rfa_pkg::DIV_DEN_W-1:0]   d_q;
	logic [TW-1:0]                   period_q;
	logic [rfa_pkg::ACC_W-1:0]       acc_q;
	logic                            div_go_q;
	logic                            out_valid_q;
	rfa_pkg::res_t                   out_q;

	logic signed [SW:0]              pv25;
	logic signed [SW:0]              op25;
	logic signed [SW:0]              ref25;
	logic signed [SW:0]              hb25;
	logic signed [SW:0]              ra25;
	logic signed [SW:0]              up25;
	logic signed [SW:0]              dn25;
	logic signed [SW:0]              hl25;
	logic signed [SW:0]              ll25;
	logic signed [SW:0]              dif25;
	logic signed [SW-1:0]            nlo;
	logic signed [SW-1:0]            nhi;
	logic signed [SW-1:0]            ref_sel;
	logic [TW-1:0]                   elapsed;
	logic [TW-1:0]                   period_new;
	logic                            sw_off;
	logic                            sw_on;
	logic                            cfg_bad;
	logic                            op_bad;
	logic                            smp_ok;
	logic                            cnt_go;
	logic [MW-1:0]                   mul_lo;
	logic [MW-1:0]                   mul_hi;
	logic [31:0]                     ku_sat;
	logic                            out_free;
	rfa_pkg::res_t                   res_new;

	logic                            div_busy;
	logic                            div_done;
	logic [rfa_pkg::DIV_NUM_W-1:0]   div_num;
	logic [rfa_pkg::DIV_DEN_W-1:0]   div_den;
	logic [rfa_pkg::DIV_NUM_W-1:0]   div_quo;

	rfa_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_go_q),
		.num   (div_num),
		.den   (div_den),
		.busy  (div_busy),
		.done  (div_done),
		.quo   (div_quo)
	);

	assign q_pop     = state_q == S_IDLE && !q_empty;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	assign pv25    = {cmd_q.pv[SW-1], cmd_q.pv};
	assign op25    = {cmd_q.opr[SW-1], cmd_q.opr};
	assign ref25   = {ref_q[SW-1], ref_q};
	assign hb25    = $signed({2'b00, cfg.hysteresis_band});
	assign ra25    = $signed({2'b00, cfg.relay_amplitude});
	assign up25    = ref25 + hb25;
	assign dn25    = ref25 - hb25;
	assign hl25    = op25 + ra25;
	assign ll25    = op25 - ra25;
	assign nlo     = (cmd_q.pv < clo_q) ? cmd_q.pv : clo_q;
	assign nhi     = (cmd_q.pv > chi_q) ? cmd_q.pv : chi_q;
	assign dif25   = {nhi[SW-1], nhi} - {nlo[SW-1], nlo};
	assign ref_sel = cmd_q.use_cur ? cmd_q.pv : cmd_q.ref_pv;
	assign elapsed    = cmd_q.now - start_t_q;
	assign period_new = cmd_q.now - lht_q;
	assign sw_off  = relay_q && (pos_q ? pv25 >= up25 : pv25 <= dn25);
	assign sw_on   = !relay_q && (pos_q ? pv25 <= dn25 : pv25 >= up25);
	assign cfg_bad = cfg.relay_amplitude == '0 || cfg.cycles_required == '0 ||
		cfg.output_min >= cfg.output_max || cfg.pv_min >= cfg.pv_max;
	assign op_bad  = cmd_q.opr < cfg.output_min || cmd_q.opr > cfg.output_max ||
		hl25 > $signed({cfg.output_max[SW-1], cfg.output_max}) ||
		ll25 < $signed({cfg.output_min[SW-1], cfg.output_min});
	assign smp_ok  = elapsed < cfg.max_test_ms &&
		cmd_q.pv >= cfg.pv_min && cmd_q.pv <= cfg.pv_max &&
		cmd_q.opr >= cfg.output_min && cmd_q.opr <= cfg.output_max;
	assign cnt_go  = cmd_q.op == rfa_pkg::OP_SAMPLE && test_q == rfa_pkg::RUN_ACTIVE &&
		smp_ok && !sw_off && sw_on && started_q && dif25 != '0 &&
		period_new != '0 && warm_q;
	assign mul_lo  = MW'(cfg.relay_amplitude) * MW'(C_LO);
	assign mul_hi  = MW'(cfg.relay_amplitude) * MW'(C_HI);
	assign ku_sat  = (div_quo[rfa_pkg::DIV_NUM_W-1:32] != '0) ? '1 : div_quo[31:0];

	always_comb begin
		unique case (state_q)
			S_DIV_KU: begin
				div_num = acc_q[rfa_pkg::ACC_W-1:16];
				div_den = d_q;
			end
			S_DIV_KM: begin
				div_num = rfa_pkg::DIV_NUM_W'(kusum_q);
				div_den = rfa_pkg::DIV_DEN_W'(cnt_q);
			end
			S_DIV_TM: begin
				div_num = rfa_pkg::DIV_NUM_W'(tusum_q);
				div_den = rfa_pkg::DIV_DEN_W'(cnt_q);
			end
			S_DIV_AM: begin
				div_num = rfa_pkg::DIV_NUM_W'(ampsum_q);
				div_den = rfa_pkg::DIV_DEN_W'(cnt_q);
			end
			default: begin
				div_num = acc_q[rfa_pkg::ACC_W-1:16];
				div_den = d_q;
			end
		endcase
	end

	always_comb begin
		res_new.drive_value       = (test_q == rfa_pkg::RUN_ACTIVE) ?
			(relay_q ? hi_q : lo_q) : bias_q;
		res_new.relay_is_high     = relay_q;
		res_new.run_state         = test_q;
		res_new.error_code        = err_q;
		res_new.completed_cycles  = cnt_q;
		res_new.ku_average        = kumean_q;
		res_new.tu_average_ms     = tumean_q;
		res_new.amplitude_average = ampmean_q;
		res_new.result_valid      = test_q == rfa_pkg::RUN_DONE && cnt_q != '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			test_q      <= rfa_pkg::RUN_IDLE;
			err_q       <= rfa_pkg::ERR_NONE;
			relay_q     <= 1'b1;
			pos_q       <= 1'b1;
			bias_q      <= '0;
			hi_q        <= '0;
			lo_q        <= '0;
			ref_q       <= '0;
			start_t_q   <= '0;
			lht_q       <= '0;
			started_q   <= 1'b0;
			warm_q      <= 1'b0;
			clo_q       <= '0;
			chi_q       <= '0;
			kusum_q     <= '0;
			tusum_q     <= '0;
			ampsum_q    <= '0;
			cnt_q       <= '0;
			kumean_q    <= '0;
			tumean_q    <= '0;
			ampmean_q   <= '0;
			div_go_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			div_go_q    <= state_q == S_MUL_HI || (div_done && (state_q == S_DIV_KU ||
				state_q == S_DIV_KM || state_q == S_DIV_TM));
			out_valid_q <= (state_q == S_EMIT && out_free) || (out_valid_q && out_stall);
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= cnt_go ? S_MUL_LO : S_EMIT;
					unique case (cmd_q.op)
						rfa_pkg::OP_START: begin
							if (test_q != rfa_pkg::RUN_ACTIVE) begin
								if (cfg_bad) begin
									test_q <= rfa_pkg::RUN_ABORT;
									err_q  <= rfa_pkg::ERR_CONFIG;
								end else begin
									bias_q <= cmd_q.opr;
									if (cmd_q.pv < cfg.pv_min) begin
										test_q <= rfa_pkg::RUN_ABORT;
										err_q  <= rfa_pkg::ERR_PV_LOW;
									end else if (cmd_q.pv > cfg.pv_max) begin
										test_q <= rfa_pkg::RUN_ABORT;
										err_q  <= rfa_pkg::ERR_PV_HIGH;
									end else if (op_bad) begin
										hi_q   <= '0;
										lo_q   <= '0;
										test_q <= rfa_pkg::RUN_ABORT;
										err_q  <= rfa_pkg::ERR_OP_LIMIT;
									end else begin
										hi_q  <= hl25[SW-1:0];
										lo_q  <= ll25[SW-1:0];
										ref_q <= ref_sel;
										if (ref_sel < cfg.pv_min || ref_sel > cfg.pv_max) begin
											test_q <= rfa_pkg::RUN_ABORT;
											err_q  <= rfa_pkg::ERR_CONFIG;
										end else begin
											pos_q     <= cmd_q.rev;
											relay_q   <= 1'b1;
											start_t_q <= cmd_q.now;
											lht_q     <= '0;
											started_q <= 1'b0;
											warm_q    <= 1'b0;
											cnt_q     <= '0;
											kusum_q   <= '0;
											tusum_q   <= '0;
											ampsum_q  <= '0;
											kumean_q  <= '0;
											tumean_q  <= '0;
											ampmean_q <= '0;
											clo_q     <= cmd_q.pv;
											chi_q     <= cmd_q.pv;
											err_q     <= rfa_pkg::ERR_NONE;
											test_q    <= rfa_pkg::RUN_ACTIVE;
										end
									end
								end
							end
						end
						rfa_pkg::OP_SAMPLE: begin
							if (test_q == rfa_pkg::RUN_ACTIVE) begin
								if (elapsed >= cfg.max_test_ms) begin
									test_q <= rfa_pkg::RUN_ABORT;
									err_q  <= (cnt_q == '0) ? rfa_pkg::ERR_NO_OSC :
										rfa_pkg::ERR_TIMEOUT;
								end else if (cmd_q.pv < cfg.pv_min) begin
									test_q <= rfa_pkg::RUN_ABORT;
									err_q  <= rfa_pkg::ERR_PV_LOW;
								end else if (cmd_q.pv > cfg.pv_max) begin
									test_q <= rfa_pkg::RUN_ABORT;
									err_q  <= rfa_pkg::ERR_PV_HIGH;
								end else if (cmd_q.opr < cfg.output_min ||
										cmd_q.opr > cfg.output_max) begin
									test_q <= rfa_pkg::RUN_ABORT;
									err_q  <= rfa_pkg::ERR_OP_LIMIT;
								end else begin
									if (sw_off) begin
										relay_q <= 1'b0;
										clo_q   <= nlo;
										chi_q   <= nhi;
									end else if (sw_on) begin
										lht_q <= cmd_q.now;
										if (started_q && dif25 != '0 && period_new != '0 &&
												warm_q) begin
											d_q      <= dif25[rfa_pkg::DIV_DEN_W-1:0];
											period_q <= period_new;
											clo_q    <= nlo;
											chi_q    <= nhi;
										end else begin
											if (started_q && dif25 != '0 &&
													period_new != '0) begin
												warm_q <= 1'b1;
											end
											started_q <= 1'b1;
											relay_q   <= 1'b1;
											clo_q     <= cmd_q.pv;
											chi_q     <= cmd_q.pv;
										end
									end else begin
										clo_q <= nlo;
										chi_q <= nhi;
									end
								end
							end
						end
						rfa_pkg::OP_ABORT: begin
							if (test_q == rfa_pkg::RUN_ACTIVE) begin
								test_q <= rfa_pkg::RUN_ABORT;
								err_q  <= rfa_pkg::ERR_USER;
							end
						end
						default: begin
						end
					endcase
				end
				S_MUL_LO: begin
					acc_q   <= rfa_pkg::ACC_W'(mul_lo);
					state_q <= S_MUL_HI;
				end
				S_MUL_HI: begin
					acc_q    <= acc_q + {mul_hi, {rfa_pkg::SPLIT_W{1'b0}}};
					state_q  <= S_DIV_KU;
				end
				S_DIV_KU: begin
					if (div_done) begin
						kusum_q  <= kusum_q + rfa_pkg::SUM_W'(ku_sat);
						tusum_q  <= tusum_q + rfa_pkg::SUM_W'(period_q);
						ampsum_q <= ampsum_q + rfa_pkg::ASUM_W'(d_q);
						cnt_q    <= cnt_q + 1'b1;
						state_q  <= S_DIV_KM;
					end
				end
				S_DIV_KM: begin
					if (div_done) begin
						kumean_q <= div_quo[31:0];
						state_q  <= S_DIV_TM;
					end
				end
				S_DIV_TM: begin
					if (div_done) begin
						tumean_q <= div_quo[TW-1:0];
						state_q  <= S_DIV_AM;
					end
				end
				S_DIV_AM: begin
					if (div_done) begin
						ampmean_q <= div_quo[SW-1:0];
						state_q   <= S_POST;
					end
				end
				S_POST: begin
					if (cnt_q >= cfg.cycles_required) begin
						test_q <= rfa_pkg::RUN_DONE;
						err_q  <= rfa_pkg::ERR_NONE;
					end else begin
						relay_q <= 1'b1;
						clo_q   <= cmd_q.pv;
						chi_q   <= cmd_q.pv;
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_data;
		end
		if (state_q == S_EMIT && out_free) begin
			out_q <= res_new;
		end
	end

	`RFA_ASSERT_IMPL(a_div_start_idle, clk, arst_n, div_go_q, !div_busy, "divider restarted while busy")
	`RFA_ASSERT_IMPL(a_div_done_state, clk, arst_n, div_done, state_q == S_DIV_KU || state_q == S_DIV_KM || state_q == S_DIV_TM || state_q == S_DIV_AM, "divider result with no consumer")
	`RFA_ASSERT_IMPL(a_cycle_span, clk, arst_n, test_q == rfa_pkg::RUN_ACTIVE, chi_q >= clo_q, "cycle maximum below minimum")
	`RFA_ASSERT_IMPL(a_post_count, clk, arst_n, state_q == S_POST, cnt_q != '0, "cycle counted with zero count")
	`RFA_ASSERT_NEXT(a_emit_load, clk, arst_n, state_q == S_EMIT && out_free, out_valid_q && state_q == S_IDLE, "result not loaded")

endmodule

// ----- rtl/relay_feedback_autotuner.sv -----
// ----------------------------------------------------------------------------
// Relay-feedback autotuner
// Top level: APB register file, front end, command queue and execution engine.
// ----------------------------------------------------------------------------
// Input transactions (in_valid/in_stall, in_item) carry start, sample and abort
// commands; each one yields exactly one result transaction (out_valid/out_stall,
// out_item) holding the drive value and the test status, in order.
// The user must write registers over the APB port only while no transaction is
// in flight; the block does not enforce this. pready is always high and reads
// return the stored value. An ordinary item passes through the EXEC and EMIT
// states to the output register. A sample that counts an oscillation cycle
// also runs a split multiplication (low half, then high half) and four passes
// of the shared bit-serial divider (Ku, then the three averages), each giving
// 41 quotient bits. The engine works one command at a time; the front stage
// and a QUEUE_DEPTH-entry queue keep taking input while it is busy, so
// in_stall rises only once both are full.
// When the receiver stalls, the result stays in the output register and the
// engine waits with its next result; input is taken until the queue fills.
// Reset clears the registers to their defaults, the test to idle with the
// relay high, and empties the queue and the output register.
// ----------------------------------------------------------------------------
module relay_feedback_autotuner #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  rfa_pkg::item_t             in_item,
	output logic                       out_valid,
	input  logic                       out_stall,
	output rfa_pkg::res_t              out_item,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rfa_pkg::CFG_AW-1:0] paddr,
	input  logic [rfa_pkg::CFG_DW-1:0] pwdata,
	output logic [rfa_pkg::CFG_DW-1:0] prdata,
	output logic                       pready
);

	rfa_pkg::cfg_t cfg_q;
	logic          cfg_wr;
	logic [2:0]    reg_idx;
	logic          q_full;
	logic          q_empty;
	logic          push;
	logic          pop;
	rfa_pkg::cmd_t push_cmd;
	rfa_pkg::cmd_t pop_cmd;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[rfa_pkg::CFG_AW-1:2];

	always_comb begin
		unique case (reg_idx)
			rfa_pkg::REG_OUTPUT_MIN:      prdata = rfa_pkg::CFG_DW'(cfg_q.output_min);
			rfa_pkg::REG_OUTPUT_MAX:      prdata = rfa_pkg::CFG_DW'(cfg_q.output_max);
			rfa_pkg::REG_PV_MIN:          prdata = rfa_pkg::CFG_DW'(cfg_q.pv_min);
			rfa_pkg::REG_PV_MAX:          prdata = rfa_pkg::CFG_DW'(cfg_q.pv_max);
			rfa_pkg::REG_RELAY_AMPLITUDE: prdata = rfa_pkg::CFG_DW'(cfg_q.relay_amplitude);
			rfa_pkg::REG_HYSTERESIS_BAND: prdata = rfa_pkg::CFG_DW'(cfg_q.hysteresis_band);
			rfa_pkg::REG_CYCLES_REQUIRED: prdata = rfa_pkg::CFG_DW'(cfg_q.cycles_required);
			default:                      prdata = cfg_q.max_test_ms;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.output_min      <= 24'sh800000;
			cfg_q.output_max      <= 24'sh7FFFFF;
			cfg_q.pv_min          <= 24'sh800000;
			cfg_q.pv_max          <= 24'sh7FFFFF;
			cfg_q.relay_amplitude <= 23'd1280;
			cfg_q.hysteresis_band <= 23'd128;
			cfg_q.cycles_required <= 8'd5;
			cfg_q.max_test_ms     <= 32'd600000;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				rfa_pkg::REG_OUTPUT_MIN:      cfg_q.output_min      <= pwdata[23:0];
				rfa_pkg::REG_OUTPUT_MAX:      cfg_q.output_max      <= pwdata[23:0];
				rfa_pkg::REG_PV_MIN:          cfg_q.pv_min          <= pwdata[23:0];
				rfa_pkg::REG_PV_MAX:          cfg_q.pv_max          <= pwdata[23:0];
				rfa_pkg::REG_RELAY_AMPLITUDE: cfg_q.relay_amplitude <= pwdata[22:0];
				rfa_pkg::REG_HYSTERESIS_BAND: cfg_q.hysteresis_band <= pwdata[22:0];
				rfa_pkg::REG_CYCLES_REQUIRED: cfg_q.cycles_required <= pwdata[7:0];
				default:                      cfg_q.max_test_ms     <= pwdata;
			endcase
		end
	end

	rfa_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item (in_item),
		.q_full  (q_full),
		.push    (push),
		.push_cmd(push_cmd)
	);

	rfa_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_cmd),
		.full     (q_full),
		.pop      (pop),
		.pop_data (pop_cmd),
		.empty    (q_empty)
	);

	rfa_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_empty  (q_empty),
		.q_data   (pop_cmd),
		.q_pop    (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item)
	);

endmodule
